// ----- rtl/core/btpc_pkg.sv -----
//------------------------------------------------------------------------------
// btpc_pkg
// Shared types, constants and helpers for the barometric compensation block.
//------------------------------------------------------------------------------
package btpc_pkg;

	localparam int RAW_W   = 20;
	localparam int TRIM_W  = 48;
	localparam int TEMP_W  = 21;
	localparam int PRESS_W = 32;
	localparam int IDX_W   = 2;

	localparam logic [RAW_W-1:0] SKIP_CODE = 20'h80000;

	localparam logic [IDX_W-1:0] REG_TRIM_TEMP    = 2'd0;
	localparam logic [IDX_W-1:0] REG_TRIM_PRESS_A = 2'd1;
	localparam logic [IDX_W-1:0] REG_TRIM_PRESS_B = 2'd2;
	localparam logic [IDX_W-1:0] REG_TRIM_PRESS_C = 2'd3;

	// datapath micro-operations, one per sequencer step
	typedef enum logic [4:0] {
		OP_T_LOAD,   // capture inputs, compute a, d
		OP_T_MUL1,   // m = a*t2
		OP_T_V1,     // v1t = m >>> 11 ; m = d*d
		OP_T_MUL2,   // m = (m>>>12)*t3
		OP_T_FIN,    // tf, fine, v1t = tf*5 ; m = 0
		OP_T_OUT,    // temperature result
		OP_P_V1,     // pv1 = fine - 128000 ; m = pv1*pv1
		OP_P_SQ,     // sq = m ; m = sq*p6
		OP_P_A1,     // acc = m ; m = pv1*p5
		OP_P_A2,     // acc += m<<17 + p4<<35 -> v2 ; m = sq*p3
		OP_P_B1,     // acc = m>>>8 ; m = pv1*p2
		OP_P_B2,     // m = (2^47+acc+m<<12)*p1
		OP_P_B3,     // den = m>>>33
		OP_P_NUM,    // m = ((1048576-adc)<<31 - v2)*3125
		OP_P_NUM2,   // not issued by the sequencer; no datapath action
		OP_P_DIV,    // start divider
		OP_P_Q,      // p = quotient ; m = p9*q
		OP_P_E1A,    // m = m*q
		OP_P_E1B,    // e1 = m>>>25 ; m = p8*p
		OP_P_E2,     // final pressure
		OP_NONE
	} op_t;

	typedef struct packed {
		logic op_valid;
		op_t  op;
	} dp_cmd_t;

	typedef struct packed {
		logic t_skip;
		logic p_skip;
		logic den_zero;
		logic div_busy;
	} dp_stat_t;

	function automatic logic signed [63:0] sx16(input logic [15:0] v);
		sx16 = {{48{v[15]}}, v};
	endfunction

endpackage

// ----- rtl/core/baro_temp_pressure_compensation_top.sv -----
//------------------------------------------------------------------------------
// baro_temp_pressure_compensation_top
// Integer temperature / pressure compensation with twelve trim coefficients.
//------------------------------------------------------------------------------
// Channel | Handshake              | Payload
// in      | in_valid / in_ready    | raw_pressure, raw_temperature
// out     | out_valid / out_ready  | temperature_centi/valid, pressure_q24_8/valid
// cfg     | cfg_we (no wait)       | cfg_index, cfg_data
//
// A full transaction makes fourteen passes through the shared multiplier and
// one through the serial divider, each step going through the run and wait
// states. A skipped temperature skips the temperature steps; a zero divisor
// skips the divide and the steps after it.
// Reset clears the sequencer, trims and the kept fine temperature.
// A result holds on the outputs until taken; no new transaction starts
// before that.
//------------------------------------------------------------------------------
module baro_temp_pressure_compensation_top import btpc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [RAW_W-1:0]         raw_pressure,
	input  logic [RAW_W-1:0]         raw_temperature,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [TEMP_W-1:0] temperature_centi,
	output logic                     temperature_valid,
	output logic [PRESS_W-1:0]       pressure_q24_8,
	output logic                     pressure_valid,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [TRIM_W-1:0]        cfg_data
);
	logic [TRIM_W-1:0] trim_t_q, trim_a_q, trim_b_q, trim_c_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// trim register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_t_q <= '0;
			trim_a_q <= '0;
			trim_b_q <= '0;
			trim_c_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRIM_TEMP:    trim_t_q <= cfg_data;
				REG_TRIM_PRESS_A: trim_a_q <= cfg_data;
				REG_TRIM_PRESS_B: trim_b_q <= cfg_data;
				REG_TRIM_PRESS_C: trim_c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	btpc_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_ready, .out_valid,
		.out_ready, .cmd, .stat);

	btpc_datapath u_dp (.clk, .arst_n, .cmd, .stat, .raw_pressure,
		.raw_temperature, .trim_t(trim_t_q), .trim_a(trim_a_q),
		.trim_b(trim_b_q), .trim_c(trim_c_q), .temperature_centi,
		.temperature_valid, .pressure_q24_8, .pressure_valid);
endmodule

// ----- rtl/core/btpc_mul64.sv -----
//------------------------------------------------------------------------------
// btpc_mul64
// 64x64 low-half multiplier, three 32x32 partial products.
//------------------------------------------------------------------------------
module btpc_mul64 import btpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        busy,
	output logic [63:0] prod
);
	logic [2:0]  step_q;
	logic [63:0] a_q, b_q, acc_q;
	logic [31:0] x, y;
	logic [63:0] pp;

	// low x low, then both cross terms; the high x high term never reaches the low half
	always_comb begin
		unique case (step_q)
			3'd4: begin x = a_q[31:0];  y = b_q[31:0];  end
			3'd3: begin x = a_q[63:32]; y = b_q[31:0];  end
			3'd2: begin x = a_q[31:0];  y = b_q[63:32]; end
			default: begin x = 32'd0;   y = 32'd0;      end
		endcase
		pp = {32'd0, x} * {32'd0, y};
	end

	assign busy = (step_q != 3'd0) || start;
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 3'd0;
		end else if (start) begin
			step_q <= 3'd4;
		end else if (step_q != 3'd0) begin
			step_q <= step_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= 64'd0;
		end else begin
			unique case (step_q)
				3'd4: acc_q <= pp;
				3'd3: acc_q <= acc_q + {pp[31:0], 32'd0};
				3'd2: acc_q <= acc_q + {pp[31:0], 32'd0};
				default: acc_q <= acc_q;
			endcase
		end
	end
endmodule

// ----- rtl/core/btpc_div64.sv -----
//------------------------------------------------------------------------------
// btpc_div64
// Signed 64-bit restoring divider, truncating toward zero, one bit a cycle.
//------------------------------------------------------------------------------
module btpc_div64 import btpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        busy,
	output logic [63:0] quot
);
	logic [6:0]  cnt_q;
	logic [63:0] q_q, r_q, d_q;
	logic        neg_q;
	logic [64:0] trial;
	logic [63:0] rs;

	assign busy = (cnt_q != 7'd0) || start;
	assign quot = neg_q ? (64'd0 - q_q) : q_q;
	assign rs    = {r_q[62:0], q_q[63]};
	assign trial = {1'b0, rs} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (cnt_q != 7'd0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num[63] ? (64'd0 - num) : num;
			d_q   <= den[63] ? (64'd0 - den) : den;
			r_q   <= 64'd0;
			neg_q <= num[63] ^ den[63];
		end else if (cnt_q != 7'd0) begin
			if (!trial[64] && !(r_q[63])) begin
				r_q <= trial[63:0];
				q_q <= {q_q[62:0], 1'b1};
			end else if (r_q[63]) begin
				r_q <= trial[63:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= rs;
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end
endmodule

// ----- rtl/core/btpc_datapath.sv -----
//------------------------------------------------------------------------------
// btpc_datapath
// Operand registers, shared multiplier and divider, result registers.
//------------------------------------------------------------------------------
module btpc_datapath import btpc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_cmd_t                   cmd,
	output dp_stat_t                  stat,
	input  logic [RAW_W-1:0]          raw_pressure,
	input  logic [RAW_W-1:0]          raw_temperature,
	input  logic [TRIM_W-1:0]         trim_t,
	input  logic [TRIM_W-1:0]         trim_a,
	input  logic [TRIM_W-1:0]         trim_b,
	input  logic [TRIM_W-1:0]         trim_c,
	output logic signed [TEMP_W-1:0]  temperature_centi,
	output logic                      temperature_valid,
	output logic [PRESS_W-1:0]        pressure_q24_8,
	output logic                      pressure_valid
);
	logic [RAW_W-1:0] adcp_q, adct_q;
	logic signed [63:0] a_q, d_q, v1t_q, pv1_q, sq_q, acc_q, v2_q, den_q, p_q, q_q, e1_q;
	logic [31:0] fine_q;
	logic signed [63:0] ma, mb;
	logic mstart, dstart, mbusy, dbusy;
	logic signed [63:0] m;
	logic [63:0] quo;
	logic signed [63:0] tf;

	function automatic logic [TEMP_W-1:0] tcv_w(input logic signed [63:0] x);
		logic signed [63:0] y;
		y = (x + 64'sd128) >>> 8;
		tcv_w = y[TEMP_W-1:0];
	endfunction

	btpc_mul64 u_mul (.clk, .arst_n, .start(mstart), .a(ma), .b(mb),
		.busy(mbusy), .prod(m));
	btpc_div64 u_div (.clk, .arst_n, .start(dstart), .num(m), .den(den_q),
		.busy(dbusy), .quot(quo));

	logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = {48'd0, trim_t[15:0]};
	assign t2 = sx16(trim_t[31:16]);
	assign t3 = sx16(trim_t[47:32]);
	assign p1 = {48'd0, trim_a[15:0]};
	assign p2 = sx16(trim_a[31:16]);
	assign p3 = sx16(trim_a[47:32]);
	assign p4 = sx16(trim_b[15:0]);
	assign p5 = sx16(trim_b[31:16]);
	assign p6 = sx16(trim_b[47:32]);
	assign p7 = sx16(trim_c[15:0]);
	assign p8 = sx16(trim_c[31:16]);
	assign p9 = sx16(trim_c[47:32]);

	logic go;
	assign go = cmd.op_valid;
	assign tf = {{32{fine_q[31]}}, fine_q};

	always_comb begin
		mstart = 1'b0; dstart = 1'b0; ma = '0; mb = '0;
		if (go) begin
			unique case (cmd.op)
				OP_T_MUL1: begin mstart = 1'b1; ma = a_q; mb = t2; end
				OP_T_V1:   begin mstart = 1'b1; ma = d_q; mb = d_q; end
				OP_T_MUL2: begin mstart = 1'b1; ma = m >>> 12; mb = t3; end
				OP_P_V1:   begin mstart = 1'b1; ma = tf - 64'sd128000;
					mb = tf - 64'sd128000; end
				OP_P_SQ:   begin mstart = 1'b1; ma = m; mb = p6; end
				OP_P_A1:   begin mstart = 1'b1; ma = pv1_q; mb = p5; end
				OP_P_A2:   begin mstart = 1'b1; ma = sq_q; mb = p3; end
				OP_P_B1:   begin mstart = 1'b1; ma = pv1_q; mb = p2; end
				OP_P_B2:   begin mstart = 1'b1; ma = (64'sd1 <<< 47) + acc_q + (m <<< 12);
					mb = p1; end
				OP_P_NUM:  begin mstart = 1'b1;
					ma = ((64'sd1048576 - $signed({44'd0, adcp_q})) <<< 31) - v2_q;
					mb = 64'sd3125; end
				OP_P_DIV:  dstart = 1'b1;
				OP_P_Q:    begin mstart = 1'b1; ma = p9; mb = $signed(quo) >>> 13; end
				OP_P_E1A:  begin mstart = 1'b1; ma = m; mb = q_q; end
				OP_P_E1B:  begin mstart = 1'b1; ma = p8; mb = p_q; end
				OP_T_FIN:  begin mstart = 1'b1; ma = '0; mb = '0; end
				default: ;
			endcase
		end
	end

	assign stat.t_skip   = (adct_q == SKIP_CODE);
	assign stat.p_skip   = (adcp_q == SKIP_CODE);
	assign stat.den_zero = (den_q == 64'd0);
	assign stat.div_busy = mbusy || dbusy;

	logic signed [63:0] tsum;
	always_comb begin
		tsum = v1t_q + (m >>> 14);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_q <= 32'd0;
		end else if (go && cmd.op == OP_T_FIN) begin
			fine_q <= tsum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			unique case (cmd.op)
				OP_T_LOAD: begin
					adcp_q <= raw_pressure;
					adct_q <= raw_temperature;
					temperature_valid <= 1'b0;
					temperature_centi <= '0;
					pressure_valid <= 1'b0;
					pressure_q24_8 <= '0;
					a_q <= $signed({47'd0, raw_temperature[19:3]}) - (t1 <<< 1);
					d_q <= $signed({48'd0, raw_temperature[19:4]}) - t1;
				end
				OP_T_V1: v1t_q <= m >>> 11;
				OP_T_FIN: v1t_q <= $signed({{32{tsum[31]}}, tsum[31:0]}) * 64'sd5;
				OP_T_OUT: begin
					temperature_valid <= 1'b1;
					if (($signed(v1t_q + 64'sd128) >>> 8) > 64'sd1048575)
						temperature_centi <= 21'h0FFFFF;
					else if (($signed(v1t_q + 64'sd128) >>> 8) < -64'sd1048576)
						temperature_centi <= 21'h100000;
					else
						temperature_centi <= tcv_w(v1t_q);
				end
				OP_P_V1: pv1_q <= tf - 64'sd128000;
				OP_P_SQ: sq_q <= m;
				OP_P_A1: acc_q <= m;
				OP_P_A2: v2_q <= acc_q + (m <<< 17) + (p4 <<< 35);
				OP_P_B1: acc_q <= m >>> 8;
				OP_P_B3: den_q <= m >>> 33;
				OP_P_Q: begin
					p_q <= quo;
					q_q <= $signed(quo) >>> 13;
				end
				OP_P_E1B: e1_q <= m >>> 25;
				OP_P_E2: begin
					pressure_valid <= 1'b1;
					pressure_q24_8 <= 32'((((p_q + e1_q + (m >>> 19)) >>> 8)) + (p7 <<< 4));
				end
				default: ;
			endcase
		end
	end
endmodule

// ----- rtl/core/btpc_ctrl.sv -----
//------------------------------------------------------------------------------
// btpc_ctrl
// Sequencer: walks the compensation steps and runs the handshakes.
//------------------------------------------------------------------------------
module btpc_ctrl import btpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RUN  = 4'b0010,
		S_WAIT = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	op_t    op_q;

	// output register frees once taken; new work only starts when empty
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd.op_valid = 1'b0;
		cmd.op = op_q;
		if (state_q == S_IDLE && in_valid) begin
			cmd.op_valid = 1'b1;
			cmd.op = OP_T_LOAD;
		end else if (state_q == S_RUN) begin
			cmd.op_valid = 1'b1;
		end
	end

	function automatic op_t next_op(input op_t o, input dp_stat_t s);
		unique case (o)
			OP_T_LOAD: next_op = s.t_skip ? OP_P_V1 : OP_T_MUL1;
			OP_T_MUL1: next_op = OP_T_V1;
			OP_T_V1:   next_op = OP_T_MUL2;
			OP_T_MUL2: next_op = OP_T_FIN;
			OP_T_FIN:  next_op = OP_T_OUT;
			OP_T_OUT:  next_op = OP_P_V1;
			OP_P_V1:   next_op = OP_P_SQ;
			OP_P_SQ:   next_op = OP_P_A1;
			OP_P_A1:   next_op = OP_P_A2;
			OP_P_A2:   next_op = OP_P_B1;
			OP_P_B1:   next_op = OP_P_B2;
			OP_P_B2:   next_op = OP_P_B3;
			OP_P_B3:   next_op = OP_P_NUM;
			OP_P_NUM:  next_op = s.den_zero ? OP_NONE : OP_P_DIV;
			OP_P_DIV:  next_op = OP_P_Q;
			OP_P_Q:    next_op = OP_P_E1A;
			OP_P_E1A:  next_op = OP_P_E1B;
			OP_P_E1B:  next_op = OP_P_E2;
			default:   next_op = OP_NONE;
		endcase
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_NONE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					op_q    <= OP_T_LOAD;
					state_q <= S_WAIT;
				end
				S_RUN: begin
					state_q <= S_WAIT;
				end
				S_WAIT: if (!stat.div_busy) begin
					priority if (op_q == OP_T_LOAD && stat.p_skip && stat.t_skip) begin
						state_q <= S_OUT;
					end else if (op_q == OP_T_OUT && stat.p_skip) begin
						state_q <= S_OUT;
					end else if (op_q == OP_T_LOAD && stat.t_skip) begin
						op_q <= stat.p_skip ? OP_NONE : OP_P_V1;
						state_q <= S_RUN;
					end else if (next_op(op_q, stat) == OP_NONE) begin
						state_q <= S_OUT;
					end else begin
						op_q <= next_op(op_q, stat);
						state_q <= S_RUN;
					end
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/core/btpc_checker.sv -----
//------------------------------------------------------------------------------
// btpc_checker
// Port-level checks on the compensation block.
//------------------------------------------------------------------------------
module btpc_checker import btpc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic temperature_valid,
	input logic signed [TEMP_W-1:0] temperature_centi,
	input logic pressure_valid,
	input logic [PRESS_W-1:0] pressure_q24_8
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("accept while result pending");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !out_valid)
		else $error("block not busy after accept");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_temp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !temperature_valid |-> temperature_centi == '0)
		else $error("skipped temperature nonzero");
	a_press_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pressure_valid |-> pressure_q24_8 == '0)
		else $error("invalid pressure nonzero");
endmodule

bind baro_temp_pressure_compensation_top btpc_checker u_chk (.clk, .arst_n,
	.in_valid, .in_ready, .out_valid, .out_ready, .temperature_valid,
	.temperature_centi, .pressure_valid, .pressure_q24_8);
